// File: rtl/mex_pkg.sv
// shared types, codes and control store for the modular exponentiation block
package mex_pkg;

    // fixed widths of the request fields
    localparam int BASE_W = 63;
    localparam int EXP_W  = 63;

    // control store addressing
    localparam int UPC_W = 4;

    // multiplier operand setup codes
    localparam logic [1:0] SET_NONE = 2'd0;
    localparam logic [1:0] SET_RED  = 2'd1;
    localparam logic [1:0] SET_AB   = 2'd2;
    localparam logic [1:0] SET_BB   = 2'd3;

    // jump condition codes
    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_REQ   = 3'd2;
    localparam logic [2:0] JC_MUL_MORE = 3'd3;
    localparam logic [2:0] JC_E_ZERO   = 3'd4;
    localparam logic [2:0] JC_E_EVEN   = 3'd5;
    localparam logic [2:0] JC_OUT_BUSY = 3'd6;

    // control store addresses
    localparam logic [UPC_W-1:0] UA_IDLE      = 4'd0;
    localparam logic [UPC_W-1:0] UA_RED_SETUP = 4'd1;
    localparam logic [UPC_W-1:0] UA_RED_LOOP  = 4'd2;
    localparam logic [UPC_W-1:0] UA_RED_STORE = 4'd3;
    localparam logic [UPC_W-1:0] UA_TEST_ZERO = 4'd4;
    localparam logic [UPC_W-1:0] UA_TEST_BIT  = 4'd5;
    localparam logic [UPC_W-1:0] UA_MUL_SETUP = 4'd6;
    localparam logic [UPC_W-1:0] UA_MUL_LOOP  = 4'd7;
    localparam logic [UPC_W-1:0] UA_MUL_STORE = 4'd8;
    localparam logic [UPC_W-1:0] UA_SQR_SETUP = 4'd9;
    localparam logic [UPC_W-1:0] UA_SQR_LOOP  = 4'd10;
    localparam logic [UPC_W-1:0] UA_SQR_STORE = 4'd11;
    localparam logic [UPC_W-1:0] UA_EMIT      = 4'd12;
    localparam logic [UPC_W-1:0] UA_RETURN    = 4'd13;

    // one control word
    typedef struct packed {
        logic             accept;
        logic [1:0]       setup;
        logic             mul_step;
        logic             wr_a;
        logic             wr_b;
        logic             shift_e;
        logic             emit;
        logic [2:0]       jcond;
        logic [UPC_W-1:0] target;
    } mex_uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic req_valid;
        logic mul_more;
        logic e_zero;
        logic e_lsb;
        logic out_busy;
    } mex_stat_t;

    // microprogram: base reduction, then right-to-left square and multiply
    function automatic mex_uword_t ucode(input logic [UPC_W-1:0] upc);
        mex_uword_t w;
        w = '0;
        w.jcond  = JC_NEXT;
        w.target = UA_IDLE;
        unique case (upc)
            UA_IDLE:
            begin
                w.accept = 1'b1;
                w.jcond  = JC_NO_REQ;
                w.target = UA_IDLE;
            end
            UA_RED_SETUP:
            begin
                w.setup = SET_RED;
            end
            UA_RED_LOOP:
            begin
                w.mul_step = 1'b1;
                w.jcond    = JC_MUL_MORE;
                w.target   = UA_RED_LOOP;
            end
            UA_RED_STORE:
            begin
                w.wr_b = 1'b1;
            end
            UA_TEST_ZERO:
            begin
                w.jcond  = JC_E_ZERO;
                w.target = UA_EMIT;
            end
            UA_TEST_BIT:
            begin
                w.jcond  = JC_E_EVEN;
                w.target = UA_SQR_SETUP;
            end
            UA_MUL_SETUP:
            begin
                w.setup = SET_AB;
            end
            UA_MUL_LOOP:
            begin
                w.mul_step = 1'b1;
                w.jcond    = JC_MUL_MORE;
                w.target   = UA_MUL_LOOP;
            end
            UA_MUL_STORE:
            begin
                w.wr_a = 1'b1;
            end
            UA_SQR_SETUP:
            begin
                w.setup = SET_BB;
            end
            UA_SQR_LOOP:
            begin
                w.mul_step = 1'b1;
                w.jcond    = JC_MUL_MORE;
                w.target   = UA_SQR_LOOP;
            end
            UA_SQR_STORE:
            begin
                w.wr_b    = 1'b1;
                w.shift_e = 1'b1;
                w.jcond   = JC_ALWAYS;
                w.target  = UA_TEST_ZERO;
            end
            UA_EMIT:
            begin
                w.emit   = 1'b1;
                w.jcond  = JC_OUT_BUSY;
                w.target = UA_EMIT;
            end
            UA_RETURN:
            begin
                w.jcond  = JC_ALWAYS;
                w.target = UA_IDLE;
            end
            default:
            begin
                w.jcond  = JC_ALWAYS;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/mex_if.sv
// request and response channel interfaces
interface mex_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [mex_pkg::BASE_W-1:0]  base;
    logic [mex_pkg::EXP_W-1:0]   exponent;

    modport source (output valid, output kind, output base, output exponent, input ready);
    modport sink (input valid, input kind, input base, input exponent, output ready);
endinterface

interface mex_rsp_if #(
    parameter int MOD_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// top level: modular exponentiation with fermat inverse mode
// sequence: base reduction, then a squaring for each exponent bit up to the highest set one,
//   plus a multiply before the squaring for each set bit
// throughput: one request at a time, the next accepted once the sequencer is back in idle
//   after the result is registered; set by the one bit-serial modular multiplier, one bit per cycle
// reset: sequencer idle, response register empty, modulus register back to 1
module modular_exponentiation #(
    parameter int MOD_BITS = 32,
    parameter int EXP_BITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [MOD_BITS-1:0] cfg_wdata,
    mex_req_if.sink             req,
    mex_rsp_if.source           rsp
);

    localparam int Y_W    = (MOD_BITS > mex_pkg::BASE_W) ? MOD_BITS : mex_pkg::BASE_W;
    localparam int CNT_W  = $clog2(Y_W + 1);
    localparam int SH_B   = Y_W - mex_pkg::BASE_W;
    localparam int SH_M   = Y_W - MOD_BITS;
    localparam logic [mex_pkg::EXP_W-1:0] EXP_MASK = (EXP_BITS >= mex_pkg::EXP_W) ?
        {mex_pkg::EXP_W{1'b1}} : mex_pkg::EXP_W'((64'd1 << EXP_BITS) - 64'd1);

    mex_pkg::mex_uword_t uword;
    mex_pkg::mex_stat_t  stat;

    logic [MOD_BITS-1:0]        modulus_reg;
    logic [MOD_BITS-1:0]        a_reg;
    logic [MOD_BITS-1:0]        b_reg;
    logic [Y_W-1:0]             e_reg;
    logic [mex_pkg::BASE_W-1:0] base_reg;
    logic                       rsp_valid_reg;
    logic [MOD_BITS-1:0]        result_reg;

    logic [MOD_BITS-1:0] m_eff;
    logic                req_fire;
    logic                out_busy;
    logic                emit_fire;
    logic                mul_load;
    logic [MOD_BITS-1:0] mul_x;
    logic [Y_W-1:0]      mul_y;
    logic [CNT_W-1:0]    mul_len;
    logic [MOD_BITS-1:0] prod;
    logic                mul_more;

    // control
    mex_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uword (uword)
    );

    assign req_fire  = uword.accept && req.valid;
    assign out_busy  = rsp_valid_reg && !rsp.ready;
    assign emit_fire = uword.emit && !out_busy;
    assign req.ready = uword.accept;

    // a zero modulus acts as one
    assign m_eff = (modulus_reg == '0) ? MOD_BITS'(1) : modulus_reg;

    // status back to the sequencer
    always_comb
    begin
        stat.req_valid = req.valid;
        stat.mul_more  = mul_more;
        stat.e_zero    = (e_reg == '0);
        stat.e_lsb     = e_reg[0];
        stat.out_busy  = out_busy;
    end

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_BITS'(1);
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    // multiplier operand selection
    always_comb
    begin
        mul_load = (uword.setup != mex_pkg::SET_NONE);
        case (uword.setup)
            mex_pkg::SET_RED:
            begin
                mul_x   = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                mul_y   = Y_W'(base_reg) << SH_B;
                mul_len = CNT_W'(mex_pkg::BASE_W);
            end
            mex_pkg::SET_AB:
            begin
                mul_x   = a_reg;
                mul_y   = Y_W'(b_reg) << SH_M;
                mul_len = CNT_W'(MOD_BITS);
            end
            default:
            begin
                mul_x   = b_reg;
                mul_y   = Y_W'(b_reg) << SH_M;
                mul_len = CNT_W'(MOD_BITS);
            end
        endcase
    end

    mex_modmul #(
        .MOD_BITS (MOD_BITS),
        .Y_W      (Y_W),
        .CNT_W    (CNT_W)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mul_load),
        .step   (uword.mul_step),
        .x_in   (mul_x),
        .y_in   (mul_y),
        .len_in (mul_len),
        .m      (m_eff),
        .prod   (prod),
        .more   (mul_more)
    );

    // accumulator, running square and exponent registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            a_reg    <= MOD_BITS'(1);
            base_reg <= req.base;
            if (req.kind)
            begin
                if (modulus_reg < MOD_BITS'(2))
                begin
                    e_reg <= '0;
                end
                else
                begin
                    e_reg <= Y_W'(modulus_reg - MOD_BITS'(2));
                end
            end
            else
            begin
                e_reg <= Y_W'(req.exponent & EXP_MASK);
            end
        end
        else
        begin
            if (uword.wr_a)
            begin
                a_reg <= prod;
            end
            if (uword.wr_b)
            begin
                b_reg <= prod;
            end
            if (uword.shift_e)
            begin
                e_reg <= e_reg >> 1;
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            result_reg <= a_reg;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.result = result_reg;

    // the accumulator stays reduced after each multiply
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        uword.wr_a |=> a_reg < m_eff)
        else $error("accumulator not below modulus");

    // a result leaves only once every exponent bit is used
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> e_reg == '0)
        else $error("result emitted with exponent bits left");

    // a waiting response holds its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result))
        else $error("response changed while stalled");

endmodule

// File: rtl/mex_modmul.sv
// bit-serial shift-add modular multiplier, one multiplier bit per cycle while step is asserted
module mex_modmul #(
    parameter int MOD_BITS = 32,
    parameter int Y_W      = 64,
    parameter int CNT_W    = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                step,
    input  logic [MOD_BITS-1:0] x_in,
    input  logic [Y_W-1:0]      y_in,
    input  logic [CNT_W-1:0]    len_in,
    input  logic [MOD_BITS-1:0] m,
    output logic [MOD_BITS-1:0] prod,
    output logic                more
);

    localparam int S_W = MOD_BITS + 2;

    logic [MOD_BITS-1:0] x_reg;
    logic [Y_W-1:0]      y_reg;
    logic [MOD_BITS-1:0] p_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [S_W-1:0] sum;
    logic [S_W-1:0] m1;
    logic [S_W-1:0] m2;
    logic [S_W-1:0] red;

    // double the partial, add the multiplicand on a set bit, fold back below m
    always_comb
    begin
        m1  = S_W'(m);
        m2  = S_W'({m, 1'b0});
        sum = S_W'({p_reg, 1'b0}) + S_W'(y_reg[Y_W-1] ? x_reg : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    // operand and partial registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            p_reg   <= '0;
            cnt_reg <= len_in;
        end
        else if (step)
        begin
            p_reg   <= red[MOD_BITS-1:0];
            y_reg   <= y_reg << 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign prod = p_reg;
    assign more = (cnt_reg != CNT_W'(1));

    // a step never runs past the last multiplier bit
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> cnt_reg != '0)
        else $error("multiplier step with empty bit count");

    // every step leaves the partial reduced
    a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> p_reg < $past(m))
        else $error("multiplier partial not below modulus");

endmodule

// File: rtl/mex_seq.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
module mex_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  mex_pkg::mex_stat_t stat,
    output mex_pkg::mex_uword_t uword
);

    logic [mex_pkg::UPC_W-1:0] upc_reg;
    logic [mex_pkg::UPC_W-1:0] upc_next;
    logic                      take;

    // control word for the current step
    assign uword = mex_pkg::ucode(upc_reg);

    // jump condition decode
    always_comb
    begin
        unique case (uword.jcond)
            mex_pkg::JC_NEXT:     take = 1'b0;
            mex_pkg::JC_ALWAYS:   take = 1'b1;
            mex_pkg::JC_NO_REQ:   take = !stat.req_valid;
            mex_pkg::JC_MUL_MORE: take = stat.mul_more;
            mex_pkg::JC_E_ZERO:   take = stat.e_zero;
            mex_pkg::JC_E_EVEN:   take = !stat.e_lsb;
            mex_pkg::JC_OUT_BUSY: take = stat.out_busy;
            default:              take = 1'b0;
        endcase
        upc_next = take ? uword.target : upc_reg + mex_pkg::UPC_W'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= mex_pkg::UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
